// ===== src/srf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srf_pkg
// Shared types and constants for stochastic binary64 to binary32 rounding.
// ----------------------------------------------------------------------------
package srf_pkg;

  localparam int unsigned RandW = 29;
  localparam logic [10:0] ExpMax64 = 11'h7FF;
  localparam logic [10:0] ExpBias = 11'd896;
  localparam logic [10:0] ExpOvf = 11'd1151;
  localparam logic [10:0] ExpSubLo = 11'd863;
  localparam logic [7:0] ExpMax32 = 8'hFF;

  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_INF,
    CLS_NAN,
    CLS_NORM,
    CLS_SUB
  } cls_t;

  typedef struct packed {
    logic sign;
    cls_t cls;
    logic [10:0] ex;
    logic [22:0] mhi;
    logic [23:0] sig;
  } dec_t;

endpackage

// ===== src/srf_sub_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srf_sub_round
// Shift a 24-bit significand into the binary32 subnormal grid, round to
// nearest even.
// ----------------------------------------------------------------------------
module srf_sub_round (
  input  logic [23:0] sig,
  input  logic [10:0] ex,
  output logic [23:0] q
);
  logic [5:0]  sh;
  logic [48:0] wide;
  logic [23:0] qt;
  logic [24:0] rem;
  logic        rnd;

  always_comb begin
    // shift in 1..25 relative to the 24-bit significand (ex 872..896)
    sh = 6'(11'd897 - ex);
    wide = {sig, 25'd0} >> sh;
    qt = wide[48:25];
    rem = wide[24:0];
    rnd = rem[24] && ((rem[23:0] != 24'd0) || qt[0]);
    q = qt + 24'(rnd);
  end
endmodule

// ===== src/stochastic_round_f64_to_f32.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stochastic_round_f64_to_f32
// Add random bits below the binary32 mantissa, truncate, convert to binary32.
// Throughput: one item per cycle while the output is not stalled; three pipeline
// stages (hi1/c1, d2, res3) with a global enable.
// A stall holds all stages; nothing is dropped or repeated.
// Reset clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module stochastic_round_f64_to_f32 (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] value_bits,
  input  logic [28:0] random_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_bits
);
  import srf_pkg::*;

  logic        v1, v2, v3;
  logic        adv;
  logic [34:0] hi1;
  logic        c1;
  logic [29:0] lo_sum;
  logic [34:0] hi_next;
  dec_t        d2_next, d2;
  logic [23:0] q_sub;
  logic [31:0] res_next;
  logic [31:0] res3;

  assign adv = !v3 || out_ready;
  assign in_ready = adv;
  assign out_valid = v3;
  assign result_bits = res3;

  // stage 1: low add
  assign lo_sum = {1'b0, value_bits[28:0]} + {1'b0, random_bits};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hi1 <= value_bits[63:29];
      c1 <= lo_sum[29];
      d2 <= d2_next;
      res3 <= res_next;
    end
  end

  // stage 2: carry into upper bits, classify
  assign hi_next = hi1 + 35'(c1);

  always_comb begin
    d2_next.sign = hi_next[34];
    d2_next.ex = hi_next[33:23];
    d2_next.mhi = hi_next[22:0];
    d2_next.sig = {1'b1, hi_next[22:0]};
    if (hi_next[33:23] == ExpMax64) begin
      d2_next.cls = (hi_next[22:0] == 23'd0) ? CLS_INF : CLS_NAN;
    end else if (hi_next[33:23] == 11'd0) begin
      d2_next.cls = CLS_ZERO;
    end else if (hi_next[33:23] >= ExpOvf) begin
      d2_next.cls = CLS_INF;
    end else if (hi_next[33:23] > ExpBias) begin
      d2_next.cls = CLS_NORM;
    end else if (hi_next[33:23] > ExpSubLo + 11'd8) begin
      d2_next.cls = CLS_SUB;
    end else begin
      d2_next.cls = CLS_ZERO;
    end
  end

  // stage 3: pack
  srf_sub_round u_sub (
    .sig (d2.sig),
    .ex  (d2.ex),
    .q   (q_sub)
  );

  always_comb begin
    case (d2.cls)
      CLS_INF:  res_next = {d2.sign, ExpMax32, 23'd0};
      CLS_NAN:  res_next = {d2.sign, ExpMax32, 1'b1, d2.mhi[21:0]};
      CLS_NORM: res_next = {d2.sign, 8'(d2.ex - ExpBias), d2.mhi};
      CLS_SUB:  res_next = {d2.sign, 7'd0, q_sub};
      default:  res_next = {d2.sign, 31'd0};
    endcase
  end

  a_no_out_without_fill: assert property (@(posedge clk) disable iff (rst)
    v3 |-> $past(v2) || $past(v3))
    else $error("result valid without upstream item");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (v3 && !out_ready) |=> v3 && $stable(res3))
    else $error("stalled result changed");
  a_nan_quiet: assert property (@(posedge clk) disable iff (rst)
    (v3 && res3[30:23] == ExpMax32 && res3[22:0] != 23'd0) |-> res3[22])
    else $error("NaN result not quiet");
endmodule
